// ===== rtl/efsr_pkg.sv =====
// Shared types, constants and fixed-point helpers for the failure/success recurrence block.
package efsr_pkg;

	localparam int unsigned FRAC_BITS = 31;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned IDX_W = 16;
	localparam int unsigned STEP_W = IDX_W + 1;
	localparam int unsigned WIN_W = 11;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned DEF_MAX_WINDOW = 1024;

	localparam logic [VAL_W-1:0] FX_ONE = VAL_W'(64'd1 << FRAC_BITS);
	localparam logic [VAL_W-1:0] DECAY_RESET = 32'd2147376276;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 11'd1;

	localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic clip;
	} sat_sum_t;

	typedef struct packed {
		logic init;
		logic gen;
	} coef_ctl_t;

	typedef struct packed {
		logic issue;
		logic hist_ok;
		logic finish_step;
		logic start_req;
	} acc_ctl_t;

	// Exact product, truncated towards zero after dropping the fraction bits.
	function automatic logic [VAL_W-1:0] fx_mul(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [2*VAL_W-1:0] p;
		p = {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
		return p[FRAC_BITS +: VAL_W];
	endfunction

	// Sum of two values no greater than one, clipped at one.
	function automatic sat_sum_t fx_add_sat(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		sat_sum_t res;
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > {1'b0, FX_ONE}) begin
			res.val = FX_ONE;
			res.clip = 1'b1;
		end else begin
			res.val = s[VAL_W-1:0];
			res.clip = 1'b0;
		end
		return res;
	endfunction

endpackage

// ===== rtl/efsr_coef.sv =====
// Coefficient generator and table: builds r^k*(1-r) for every window slot and holds r^m.
module efsr_coef import efsr_pkg::*; #(
	parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic clk,
	input  logic arst_n,
	input  coef_ctl_t ctl,
	input  logic [VAL_W-1:0] ratio,
	input  logic [VAL_W-1:0] one_minus,
	input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] wr_addr,
	input  logic rd_en,
	input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] rd_addr,
	output logic [VAL_W-1:0] rd_data,
	output logic [VAL_W-1:0] power
);

	logic [VAL_W-1:0] coef_mem [MAX_WINDOW];
	logic [VAL_W-1:0] pow_q;
	logic [VAL_W-1:0] rd_data_q;

	// The running power advances by one factor of r for each table entry written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow_q <= '0;
		end else if (ctl.init) begin
			pow_q <= FX_ONE;
		end else if (ctl.gen) begin
			pow_q <= fx_mul(pow_q, ratio);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.gen) begin
			coef_mem[wr_addr] <= fx_mul(pow_q, one_minus);
		end
		if (rd_en) begin
			rd_data_q <= coef_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign power = pow_q;

endmodule

// ===== rtl/efsr_hist.sv =====
// History ring memory holding the earlier step values of the current request.
module efsr_hist import efsr_pkg::*; #(
	parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] wr_addr,
	input  logic [VAL_W-1:0] wr_data,
	input  logic rd_en,
	input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] rd_addr,
	output logic [VAL_W-1:0] rd_data
);

	logic [VAL_W-1:0] hist_mem [MAX_WINDOW];
	logic [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= hist_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/efsr_acc.sv =====
// Multiply and saturating accumulate pipeline for one recurrence step.
module efsr_acc import efsr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  acc_ctl_t ctl,
	input  logic [VAL_W-1:0] coef_data,
	input  logic [VAL_W-1:0] hist_data,
	input  logic [VAL_W-1:0] power,
	output logic busy,
	output sat_sum_t fin,
	output logic sat_flag
);

	logic v_s1;
	logic ok_s1;
	logic v_s2;
	logic [VAL_W-1:0] prod_s2;
	logic [VAL_W-1:0] acc_q;
	logic sat_q;
	sat_sum_t sum;

	// Memory data arrives in the cycle after the read is issued; history slots not yet
	// written in this request count as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			if (ctl.start_req) begin
				sat_q <= 1'b0;
			end else if (v_s2 && sum.clip) begin
				sat_q <= 1'b1;
			end else if (ctl.finish_step && fin.clip) begin
				sat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= ctl.hist_ok;
		prod_s2 <= fx_mul(coef_data, ok_s1 ? hist_data : '0);
		if (ctl.start_req || ctl.finish_step) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= sum.val;
		end
	end

	assign sum = fx_add_sat(acc_q, prod_s2);
	assign fin = fx_add_sat(acc_q, power);
	assign busy = v_s1 | v_s2;
	assign sat_flag = sat_q;

endmodule

// ===== rtl/exp_failure_success_recurrence_top.sv =====
// Top level of the failure/success recurrence block: registers, sequencer and memories.
//
//  Channel | Handshake            | Word
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | last_index (16 bits)
//  out     | out_valid / out_ready| probability_value (32 bits), saturated (1 bit)
//  cfg     | cfg_valid / cfg_ready| cfg_index (0 decay_ratio, 1 window_length), cfg_data
//
// A request first builds the coefficient table for m, the clipped window length; then every
// step up to n, the requested index, streams m reads of the history and coefficient memories
// through one multiplier and a saturating adder, drains that pipeline and writes the step
// value back.
// The history ring is never swept clean: a slot older than the start of the request is
// recognised from the step counter and read as zero, so no clearing pass follows reset.
// A finished word waits in the output register; a new request is taken while it waits, and
// the sequencer only stalls at its end if the previous word has still not been taken.
module exp_failure_success_recurrence_top import efsr_pkg::*; #(
	parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [IDX_W-1:0] last_index,
	output logic out_valid,
	input  logic out_ready,
	output logic [VAL_W-1:0] probability_value,
	output logic saturated,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0] cfg_data
);

	localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned MW_W = $clog2(MAX_WINDOW + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
	localparam logic [MW_W-1:0] WIN_MAX = MW_W'(MAX_WINDOW);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COEF  = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	// Configuration registers.
	logic [VAL_W-1:0] decay_q;
	logic [WIN_W-1:0] window_q;

	// Request state.
	logic [2:0] state_q;
	logic [IDX_W-1:0] n_q;
	logic [VAL_W-1:0] ratio_q;
	logic [VAL_W-1:0] omr_q;
	logic [MW_W-1:0] m_q;
	logic [MW_W-1:0] k_q;
	logic [STEP_W-1:0] i_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [VAL_W-1:0] result_q;

	// Output register.
	logic out_valid_q;
	logic [VAL_W-1:0] prob_q;
	logic sat_out_q;

	logic in_acc;
	logic [VAL_W-1:0] ratio_clip;
	logic [MW_W-1:0] m_clip;
	logic [AW-1:0] wp_first;
	logic k_done;
	logic out_load;
	logic acc_busy;
	logic acc_sat;
	sat_sum_t step_fin;
	coef_ctl_t coef_ctl;
	acc_ctl_t acc_ctl;
	logic [VAL_W-1:0] coef_rd;
	logic [VAL_W-1:0] hist_rd;
	logic [VAL_W-1:0] power_m;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign ratio_clip = (decay_q > FX_ONE) ? FX_ONE : decay_q;
	assign m_clip = (32'(window_q) > 32'(MAX_WINDOW)) ? WIN_MAX : MW_W'(window_q);
	assign wp_first = (m_q == WIN_MAX) ? '0 : m_q[AW-1:0];
	assign k_done = (k_q == m_q);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		coef_ctl.init = in_acc;
		coef_ctl.gen = (state_q == ST_COEF) && !k_done;
		acc_ctl.start_req = in_acc;
		acc_ctl.issue = (state_q == ST_ISSUE) && !k_done;
		// Only slots written since the request began carry history: k < i - m.
		acc_ctl.hist_ok = STEP_W'(k_q) < (i_q - STEP_W'(m_q));
		acc_ctl.finish_step = (state_q == ST_DRAIN) && !acc_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DECAY: decay_q <= cfg_data;
				REG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: coefficient pass, then per step a burst of reads, a drain and a write-back, then the output load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						k_q <= '0;
						state_q <= ST_COEF;
					end
				end
				ST_COEF: begin
					if (k_done) begin
						k_q <= '0;
						if (STEP_W'(n_q) < STEP_W'(m_q)) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_ISSUE;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_ISSUE: begin
					if (k_done) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!acc_busy) begin
						k_q <= '0;
						if (i_q == STEP_W'(n_q)) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload: index, ratio, window length, step counter, ring pointers and the latest step value.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q <= last_index;
			ratio_q <= ratio_clip;
			omr_q <= FX_ONE - ratio_clip;
			m_q <= m_clip;
			result_q <= '0;
		end
		if (state_q == ST_COEF && k_done) begin
			i_q <= STEP_W'(m_q);
			wp_q <= wp_first;
			rp_q <= (wp_first == '0) ? LAST_SLOT : wp_first - 1'b1;
		end
		if (acc_ctl.issue) begin
			rp_q <= (rp_q == '0) ? LAST_SLOT : rp_q - 1'b1;
		end
		if (acc_ctl.finish_step) begin
			result_q <= step_fin.val;
			i_q <= i_q + 1'b1;
			rp_q <= wp_q;
			wp_q <= (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			prob_q <= result_q;
			sat_out_q <= acc_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign probability_value = prob_q;
	assign saturated = sat_out_q;

	efsr_coef #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_coef (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(coef_ctl),
		.ratio(ratio_q),
		.one_minus(omr_q),
		.wr_addr(k_q[AW-1:0]),
		.rd_en(acc_ctl.issue),
		.rd_addr(k_q[AW-1:0]),
		.rd_data(coef_rd),
		.power(power_m)
	);

	efsr_hist #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_hist (
		.clk(clk),
		.wr_en(acc_ctl.finish_step),
		.wr_addr(wp_q),
		.wr_data(step_fin.val),
		.rd_en(acc_ctl.issue),
		.rd_addr(rp_q),
		.rd_data(hist_rd)
	);

	efsr_acc u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(acc_ctl),
		.coef_data(coef_rd),
		.hist_data(hist_rd),
		.power(power_m),
		.busy(acc_busy),
		.fin(step_fin),
		.sat_flag(acc_sat)
	);

endmodule
